// ===== hw/rtl/tgdw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text glyph display writer package
// Shared constants, the queued job record and the 5x7 font table.
// ----------------------------------------------------------------------------
package tgdw_pkg;

    localparam int GLYPH_COUNT_DEFAULT = 91;
    localparam int GLYPH_WIDTH_DEFAULT = 5;

    localparam int STORED_GLYPHS = 91;
    localparam int STORED_COLS   = 5;
    localparam int ROM_ROW_W     = STORED_COLS * 8;

    localparam logic [7:0] FIRST_CODE          = 8'h20;
    localparam logic [7:0] PAGE_CMD_BASE       = 8'hB0;
    localparam logic [7:0] HIGH_CMD_BASE       = 8'h10;
    localparam logic [7:0] NIBBLE_MASK         = 8'h0F;
    localparam logic [7:0] CHAR_ADVANCE        = 8'd6;
    localparam logic [7:0] BLANK_COLUMN        = 8'h00;
    localparam logic [7:0] COLUMN_OFFSET_RESET = 8'd2;

    localparam int QUEUE_DEPTH = 2;

    // Write slots of one character: three commands, then the glyph columns,
    // then the spacer column.
    localparam int STEP_PAGE  = 0;
    localparam int STEP_LOW   = 1;
    localparam int STEP_HIGH  = 2;
    localparam int CMD_WRITES = 3;

    typedef struct packed {
        logic       bad;
        logic [2:0] page_row;
        logic [7:0] addr;
        logic [7:0] glyph_idx;
    } job_t;

    // Each row holds the columns of one glyph, leftmost column in the top byte.
    localparam logic [ROM_ROW_W-1:0] FONT_ROM [STORED_GLYPHS] = '{
        40'h0000000000, 40'h00004f0000, 40'h0007000700,
        40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001c224100,
        40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
        40'h4261514946, 40'h2141454b31, 40'h1814127f10,
        40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413e,
        40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
        40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
        40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
        40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
        40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7f48444438, 40'h3844444420, 40'h384444487f,
        40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
        40'h7c08040478, 40'h3844444438, 40'h7c14141408,
        40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
        40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
        40'h4464544c44
    };

    function automatic logic [7:0] font_column(input logic [7:0] idx, input logic [2:0] col);
        logic [ROM_ROW_W-1:0] row;
        logic [7:0]           byte_out;
        byte_out = BLANK_COLUMN;
        row      = '0;
        if ((idx < 8'(STORED_GLYPHS)) && (col < 3'(STORED_COLS)))
        begin
            row      = FONT_ROM[idx[6:0]];
            byte_out = row[(STORED_COLS - 1 - int'(col)) * 8 +: 8];
        end
        return byte_out;
    endfunction

endpackage

// ===== hw/rtl/tgdw_if.sv =====
// ----------------------------------------------------------------------------
// Text glyph display writer channels
// Character input channel and display bus write channel.
// ----------------------------------------------------------------------------
interface tgdw_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic [2:0] page_row;
    logic [7:0] start_column;
    logic       first_of_string;

    modport source (output valid, char_code, page_row, start_column, first_of_string,
                    input ready);
    modport sink   (input valid, char_code, page_row, start_column, first_of_string,
                    output ready);
endinterface

interface tgdw_write_if;
    logic       valid;
    logic       ready;
    logic       is_data;
    logic [7:0] bus_byte;
    logic       bad_char;
    logic       last_of_char;

    modport source (output valid, is_data, bus_byte, bad_char, last_of_char,
                    input ready);
    modport sink   (input valid, is_data, bus_byte, bad_char, last_of_char,
                    output ready);
endinterface

// ===== hw/rtl/tgdw_front.sv =====
// ----------------------------------------------------------------------------
// Text glyph display writer front end
// Accepts characters, tracks the running column and classifies the code.
// ----------------------------------------------------------------------------
module tgdw_front #(
    parameter int GLYPH_COUNT = tgdw_pkg::GLYPH_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    tgdw_char_if.sink         chars,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    output logic              push_valid,
    input  logic              push_ready,
    output tgdw_pkg::job_t    push_job
);

    logic [7:0] column_offset_reg;
    logic [7:0] column_offset_next;
    logic [7:0] running_column_reg;
    logic [7:0] running_column_next;
    logic [7:0] column;
    logic [7:0] glyph_idx;
    logic       accept;
    logic       bad;

    assign chars.ready = push_ready;
    assign push_valid  = chars.valid;
    assign accept      = chars.valid && push_ready;

    assign column    = chars.first_of_string ? chars.start_column : running_column_reg;
    assign glyph_idx = chars.char_code - tgdw_pkg::FIRST_CODE;
    assign bad       = (chars.char_code < tgdw_pkg::FIRST_CODE)
                    || ({1'b0, glyph_idx} >= 9'(GLYPH_COUNT))
                    || (glyph_idx >= 8'(tgdw_pkg::STORED_GLYPHS));

    always_comb
    begin
        push_job.bad       = bad;
        push_job.page_row  = chars.page_row;
        push_job.addr      = column + column_offset_reg;
        push_job.glyph_idx = glyph_idx;
    end

    always_comb
    begin
        column_offset_next  = cfg_we ? cfg_wdata : column_offset_reg;
        running_column_next = accept ? column + tgdw_pkg::CHAR_ADVANCE : running_column_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg  <= tgdw_pkg::COLUMN_OFFSET_RESET;
            running_column_reg <= '0;
        end
        else
        begin
            column_offset_reg  <= column_offset_next;
            running_column_reg <= running_column_next;
        end
    end

endmodule

// ===== hw/rtl/tgdw_queue.sv =====
// ----------------------------------------------------------------------------
// Text glyph display writer job queue
// Short first-in first-out queue between the front end and the write sequencer.
// ----------------------------------------------------------------------------
module tgdw_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  tgdw_pkg::job_t    push_job,
    output logic              pop_valid,
    input  logic              pop_ready,
    output tgdw_pkg::job_t    pop_job
);

    localparam int DEPTH = tgdw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tgdw_pkg::job_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Job queue holds more entries than its depth.");

endmodule

// ===== hw/rtl/tgdw_back.sv =====
// ----------------------------------------------------------------------------
// Text glyph display writer back end
// Issues a character's command, glyph and spacer writes, a cycle each while ready.
// ----------------------------------------------------------------------------
module tgdw_back #(
    parameter int GLYPH_WIDTH = tgdw_pkg::GLYPH_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  tgdw_pkg::job_t    pop_job,
    tgdw_write_if.source      writes
);

    localparam int WRITES = GLYPH_WIDTH + tgdw_pkg::CMD_WRITES + 1;
    localparam int STEP_W = $clog2(WRITES);
    localparam logic [STEP_W-1:0] LAST_STEP   = STEP_W'(WRITES - 1);
    localparam logic [STEP_W-1:0] GLYPH_FIRST = STEP_W'(tgdw_pkg::CMD_WRITES);

    tgdw_pkg::job_t    job_reg;
    tgdw_pkg::job_t    job_next;
    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              is_data_reg;
    logic              is_data_next;
    logic [7:0]        bus_byte_reg;
    logic [7:0]        bus_byte_next;
    logic              bad_char_reg;
    logic              bad_char_next;
    logic              last_reg;
    logic              last_next;
    logic              advance;
    logic              take;
    logic              at_last;
    logic [2:0]        glyph_col;

    assign advance   = !out_valid_reg || writes.ready;
    assign at_last   = (step_reg == LAST_STEP);
    assign take      = advance && (!busy_reg || at_last);
    assign pop_ready = take;
    assign glyph_col = 3'(step_reg - GLYPH_FIRST);

    always_comb
    begin
        job_next       = job_reg;
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        is_data_next   = is_data_reg;
        bus_byte_next  = bus_byte_reg;
        bad_char_next  = bad_char_reg;
        last_next      = last_reg;

        if (advance)
        begin
            out_valid_next = busy_reg;
            bad_char_next  = job_reg.bad;
            last_next      = at_last;
            is_data_next   = (step_reg >= GLYPH_FIRST);
            if (step_reg == STEP_W'(tgdw_pkg::STEP_PAGE))
            begin
                bus_byte_next = tgdw_pkg::PAGE_CMD_BASE + {5'b0, job_reg.page_row};
            end
            else if (step_reg == STEP_W'(tgdw_pkg::STEP_LOW))
            begin
                bus_byte_next = job_reg.addr & tgdw_pkg::NIBBLE_MASK;
            end
            else if (step_reg == STEP_W'(tgdw_pkg::STEP_HIGH))
            begin
                bus_byte_next = tgdw_pkg::HIGH_CMD_BASE
                              + ((job_reg.addr >> 4) & tgdw_pkg::NIBBLE_MASK);
            end
            else if (at_last || job_reg.bad)
            begin
                bus_byte_next = tgdw_pkg::BLANK_COLUMN;
            end
            else
            begin
                bus_byte_next = tgdw_pkg::font_column(job_reg.glyph_idx, glyph_col);
            end

            if (busy_reg && !at_last)
            begin
                step_next = step_reg + 1'b1;
            end
        end

        if (take)
        begin
            busy_next = pop_valid;
            step_next = '0;
            job_next  = pop_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        is_data_reg  <= is_data_next;
        bus_byte_reg <= bus_byte_next;
        bad_char_reg <= bad_char_next;
        last_reg     <= last_next;
    end

    assign writes.valid        = out_valid_reg;
    assign writes.is_data      = is_data_reg;
    assign writes.bus_byte     = bus_byte_reg;
    assign writes.bad_char     = bad_char_reg;
    assign writes.last_of_char = last_reg;

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= LAST_STEP)
        else $error("Write step counter ran past the spacer write.");

    a_busy_until_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !at_last |=> busy_reg)
        else $error("Sequencer dropped a character before its spacer write.");

    a_spacer_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> is_data_reg && (bus_byte_reg == tgdw_pkg::BLANK_COLUMN))
        else $error("Final write of a character is not a blank data column.");

    a_pop_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !at_last |-> !pop_ready)
        else $error("Sequencer took a new job in the middle of a character.");

endmodule

// ===== hw/rtl/text_glyph_display_writer.sv =====
// The first write of a character passes the queue slot, the sequencer's job register
// and its output register. The sequencer issues one bus write per cycle while the
// bus is ready, and takes the next character as it issues the current spacer write.
// A two-entry job queue lets new characters enter while earlier ones are written.
// Reset is asynchronous: the column offset returns to 2, the running column to 0,
// and all queues and sequencers are emptied; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Text glyph display writer
// Turns characters into page, column and 5x7 glyph writes for a display controller.
// ----------------------------------------------------------------------------
module text_glyph_display_writer #(
    parameter int GLYPH_COUNT = tgdw_pkg::GLYPH_COUNT_DEFAULT,
    parameter int GLYPH_WIDTH = tgdw_pkg::GLYPH_WIDTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    tgdw_char_if.sink     chars,
    tgdw_write_if.source  writes,
    input  logic          cfg_we,
    input  logic [7:0]    cfg_wdata
);

    logic           push_valid;
    logic           push_ready;
    tgdw_pkg::job_t push_job;
    logic           pop_valid;
    logic           pop_ready;
    tgdw_pkg::job_t pop_job;

    tgdw_front #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    tgdw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    tgdw_back #(
        .GLYPH_WIDTH (GLYPH_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .writes    (writes)
    );

endmodule
